// ===== src/ftba_pkg.sv =====
// Shared types and codes for the file table block allocator.
package ftba_pkg;

  localparam int ID_W     = 31;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;
  localparam int BLKNUM_W = 9;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = $clog2(WORD_W);

  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_INODE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   file_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   inode_slot;
    logic [BLKNUM_W-1:0] block_number;
  } rsp_t;

endpackage

// ===== src/ftba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ftba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/file_table_block_allocator.sv =====
// Inode table and block bitmap allocator: create, delete and look up files.
// One request at a time. Every request sweeps the inode RAM, one entry a cycle,
// stopping at the first id match.
// A create then sweeps the bitmap RAM one 32-bit row a cycle and commits in
// S_COMMIT; a delete adds a bitmap read-modify-write in S_DRD and S_DWR.
// Synchronous reset: all inodes free, blocks 0 and 1 used; done by valid flops.
module file_table_block_allocator import ftba_pkg::*; #(
  parameter int NUM_BLOCKS = 512,
  parameter int NUM_INODES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IX_W  = (NUM_INODES > 1) ? $clog2(NUM_INODES) : 1;
  localparam int BI_W  = $clog2(NUM_BLOCKS);
  localparam int ENT_W = ID_W + BI_W;
  localparam int ROWS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int RA_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int TAIL  = NUM_BLOCKS - (ROWS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK =
    (TAIL == WORD_W) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));
  localparam logic [WORD_W-1:0] RST_ROW = WORD_W'(3);

  typedef enum logic [2:0] {
    S_IDLE, S_ISCAN, S_BSCAN, S_COMMIT, S_DRD, S_DWR, S_DONE
  } state_t;

  state_t                state;
  req_t                  op;
  logic [IX_W:0]         icnt;
  logic                  ichk;
  logic [IX_W-1:0]       ichk_idx;
  logic                  ihit;
  logic [IX_W-1:0]       hit_slot;
  logic [BI_W-1:0]       hit_blk;
  logic                  ffree;
  logic [IX_W-1:0]       free_slot;
  logic [NUM_INODES-1:0] ivalid;
  logic [RA_W:0]         rcnt;
  logic                  rchk;
  logic [RA_W-1:0]       rchk_idx;
  logic                  bhit;
  logic [RA_W-1:0]       frow;
  logic [BIT_W-1:0]      fbit;
  logic [WORD_W-1:0]     fword;
  logic [ROWS-1:0]       row_valid;
  logic [RA_W-1:0]       drow;
  logic [BIT_W-1:0]      dbit;
  rsp_t                  res;

  logic [ENT_W-1:0]      ino_q;
  logic                  ino_we;
  logic [ENT_W-1:0]      ino_wdata;
  logic [WORD_W-1:0]     bm_q;
  logic                  bm_we;
  logic [RA_W-1:0]       bm_waddr;
  logic [WORD_W-1:0]     bm_wdata;
  logic [RA_W-1:0]       bm_raddr;

  logic [ID_W-1:0]       ent_id;
  logic                  i_match;
  logic                  i_free;
  logic                  i_done;
  logic [WORD_W-1:0]     b_word;
  logic [WORD_W-1:0]     b_eff;
  logic                  b_hit;
  logic [BIT_W-1:0]      b_pos;
  logic                  b_done;
  logic [WORD_W-1:0]     d_word;
  logic [BI_W-1:0]       fblk;
  logic [BI_W+BIT_W-1:0] hb_ext;
  logic                  out_free;

  function automatic logic [SLOT_W-1:0] slot_field(logic [IX_W-1:0] s);
    logic [IX_W+SLOT_W-1:0] t;
    t = {{SLOT_W{1'b0}}, s};
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [BLKNUM_W-1:0] blk_field(logic [BI_W-1:0] b);
    logic [BI_W+BLKNUM_W-1:0] t;
    t = {{BLKNUM_W{1'b0}}, b};
    return t[BLKNUM_W-1:0];
  endfunction

  ftba_ram #(.WIDTH(ENT_W), .DEPTH(NUM_INODES)) u_inode_ram (
    .clk   (clk),
    .we    (ino_we),
    .waddr (free_slot),
    .wdata (ino_wdata),
    .raddr (icnt[IX_W-1:0]),
    .rdata (ino_q)
  );

  ftba_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_bitmap_ram (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (bm_raddr),
    .rdata (bm_q)
  );

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // inode sweep
  assign ent_id  = ino_q[ENT_W-1:BI_W];
  assign i_match = ichk && !ihit && ivalid[ichk_idx] && (ent_id == op.file_id);
  assign i_free  = ichk && !ihit && !ffree && !ivalid[ichk_idx];
  assign i_done  = ihit || ((icnt == (IX_W+1)'(NUM_INODES)) && !ichk);

  // bitmap sweep
  always_comb begin
    b_word = row_valid[rchk_idx] ? bm_q : ((rchk_idx == '0) ? RST_ROW : '0);
    b_eff  = (rchk_idx == RA_W'(ROWS - 1)) ? (b_word | TAIL_MASK) : b_word;
    b_pos  = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (!b_eff[j]) begin
        b_pos = BIT_W'(j);
      end
    end
  end

  assign b_hit  = rchk && !bhit && (b_eff != '1);
  assign b_done = bhit || ((rcnt == (RA_W+1)'(ROWS)) && !rchk);

  assign fblk   = BI_W'({frow, fbit});
  assign hb_ext = {{BIT_W{1'b0}}, hit_blk};
  assign d_word = row_valid[drow] ? bm_q : ((drow == '0) ? RST_ROW : '0);

  assign bm_raddr  = (state == S_DRD) ? drow : rcnt[RA_W-1:0];
  assign ino_we    = (state == S_COMMIT);
  assign ino_wdata = {op.file_id, fblk};
  assign bm_we     = (state == S_COMMIT) || (state == S_DWR);
  assign bm_waddr  = (state == S_COMMIT) ? frow : drow;
  assign bm_wdata  = (state == S_COMMIT) ? (fword | (WORD_W'(1) << fbit))
                                         : (d_word & ~(WORD_W'(1) << dbit));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ivalid    <= '0;
      row_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req;
            icnt  <= '0;
            ichk  <= 1'b0;
            ihit  <= 1'b0;
            ffree <= 1'b0;
            state <= S_ISCAN;
          end
        end
        S_ISCAN: begin
          if (i_done) begin
            ichk <= 1'b0;
            if (op.mode == MODE_CREATE) begin
              if (ihit) begin
                res   <= '{ST_EXISTS, '0, '0};
                state <= S_DONE;
              end else begin
                rcnt  <= '0;
                rchk  <= 1'b0;
                bhit  <= 1'b0;
                state <= S_BSCAN;
              end
            end else if (!ihit) begin
              res   <= '{ST_NOT_FOUND, '0, '0};
              state <= S_DONE;
            end else if (op.mode == MODE_DELETE) begin
              res              <= '{ST_OK, slot_field(hit_slot), blk_field(hit_blk)};
              ivalid[hit_slot] <= 1'b0;
              drow             <= hb_ext[RA_W+BIT_W-1:BIT_W];
              dbit             <= hb_ext[BIT_W-1:0];
              if ({1'b0, hit_blk} < (BI_W+1)'(NUM_BLOCKS)) begin
                state <= S_DRD;
              end else begin
                state <= S_DONE;
              end
            end else begin
              res   <= '{ST_OK, slot_field(hit_slot), blk_field(hit_blk)};
              state <= S_DONE;
            end
          end else begin
            if (i_match) begin
              ihit     <= 1'b1;
              hit_slot <= ichk_idx;
              hit_blk  <= ino_q[BI_W-1:0];
            end
            if (i_free) begin
              ffree     <= 1'b1;
              free_slot <= ichk_idx;
            end
            if (!ihit && !i_match && (icnt != (IX_W+1)'(NUM_INODES))) begin
              ichk     <= 1'b1;
              ichk_idx <= icnt[IX_W-1:0];
              icnt     <= icnt + (IX_W+1)'(1);
            end else begin
              ichk <= 1'b0;
            end
          end
        end
        S_BSCAN: begin
          if (b_done) begin
            rchk <= 1'b0;
            if (!bhit) begin
              res   <= '{ST_NO_BLOCK, '0, '0};
              state <= S_DONE;
            end else if (!ffree) begin
              res   <= '{ST_NO_INODE, '0, '0};
              state <= S_DONE;
            end else begin
              res   <= '{ST_OK, slot_field(free_slot), blk_field(fblk)};
              state <= S_COMMIT;
            end
          end else begin
            if (b_hit) begin
              bhit  <= 1'b1;
              frow  <= rchk_idx;
              fbit  <= b_pos;
              fword <= b_word;
            end
            if (!bhit && !b_hit && (rcnt != (RA_W+1)'(ROWS))) begin
              rchk     <= 1'b1;
              rchk_idx <= rcnt[RA_W-1:0];
              rcnt     <= rcnt + (RA_W+1)'(1);
            end else begin
              rchk <= 1'b0;
            end
          end
        end
        S_COMMIT: begin
          ivalid[free_slot] <= 1'b1;
          row_valid[frow]   <= 1'b1;
          state             <= S_DONE;
        end
        S_DRD: begin
          state <= S_DWR;
        end
        S_DWR: begin
          row_valid[drow] <= 1'b1;
          state           <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // reserved blocks never freed
  a_reserved_kept: assert property (@(posedge clk) disable iff (rst)
    (bm_we && (bm_waddr == '0)) |-> (bm_wdata[1:0] == 2'b11))
    else $error("reserved block cleared");

  a_inode_free_on_write: assert property (@(posedge clk) disable iff (rst)
    ino_we |-> !ivalid[free_slot])
    else $error("inode written over a live entry");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_ISCAN))
    else $error("accepted request did not start a sweep");

  a_commit_pairs: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> (bm_we && ino_we && bhit && ffree))
    else $error("create commit without both block and inode");

  a_ok_create_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) |-> (fblk >= BI_W'(2)))
    else $error("create allocated a reserved block");

endmodule

// ===== verif/file_table_block_allocator_tb.sv =====
// Self-checking testbench for the file table block allocator: directed and random file ops.
`timescale 1ns / 1ps

module file_table_block_allocator_tb;
  import ftba_pkg::*;

  localparam int NUM_BLOCKS = 512;
  localparam int NUM_INODES = 32;
  localparam int POOL_SIZE  = 48;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam int TAIL_LEN   = 80;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
  localparam logic [WORD_W-1:0] FREE_ID     = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0]   ID_MAX      = 31'h7FFF_FFFF;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // shadow of the inode table and block bitmap
  logic [WORD_W-1:0]   tbl_id  [NUM_INODES];
  logic [BLKNUM_W-1:0] tbl_blk [NUM_INODES];
  bit                  blk_used[NUM_BLOCKS];

  rsp_t             expected_rsps[$];
  logic [ID_W-1:0]  id_pool[POOL_SIZE];
  int               err_count;
  int               idle_cycles;
  int               gap_pct;
  int               stall_pct;
  bit               hold_off;
  rsp_t             want;

  file_table_block_allocator #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .NUM_INODES(NUM_INODES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_file_table();
    for (int i = 0; i < NUM_INODES; i++) begin
      tbl_id[i]  = FREE_ID;
      tbl_blk[i] = '1;
    end
    for (int i = 0; i < NUM_BLOCKS; i++) blk_used[i] = 1'b0;
    blk_used[0] = 1'b1;
    blk_used[1] = 1'b1;
  endfunction

  function automatic rsp_t apply_file_op(req_t r);
    rsp_t o;
    int hit;
    int fb;
    int fi;
    logic [BLKNUM_W-1:0] b;
    o   = '0;
    hit = -1;
    fb  = -1;
    fi  = -1;
    for (int i = 0; i < NUM_INODES; i++)
      if (hit < 0 && tbl_id[i] == {1'b0, r.file_id}) hit = i;
    if (r.mode == MODE_CREATE) begin
      if (hit >= 0) begin
        o.status = ST_EXISTS;
      end else begin
        for (int i = 0; i < NUM_BLOCKS; i++)
          if (fb < 0 && !blk_used[i]) fb = i;
        for (int i = 0; i < NUM_INODES; i++)
          if (fi < 0 && tbl_id[i] == FREE_ID) fi = i;
        if (fb < 0) begin
          o.status = ST_NO_BLOCK;
        end else if (fi < 0) begin
          o.status = ST_NO_INODE;
        end else begin
          blk_used[fb] = 1'b1;
          tbl_id[fi]   = {1'b0, r.file_id};
          tbl_blk[fi]  = BLKNUM_W'(fb);
          o.status       = ST_OK;
          o.inode_slot   = SLOT_W'(fi);
          o.block_number = BLKNUM_W'(fb);
        end
      end
    end else if (hit < 0) begin
      o.status = ST_NOT_FOUND;
    end else begin
      b = tbl_blk[hit];
      o.status       = ST_OK;
      o.inode_slot   = SLOT_W'(hit);
      o.block_number = b;
      if (r.mode == MODE_DELETE) begin
        if (int'(b) < NUM_BLOCKS) blk_used[b] = 1'b0;
        tbl_id[hit]  = FREE_ID;
        tbl_blk[hit] = '1;
      end
    end
    return o;
  endfunction

  function automatic int pick_gap();
    if (int'($urandom_range(0, 99)) >= gap_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ID_W-1:0] pick_live_id();
    int live[$];
    for (int i = 0; i < NUM_INODES; i++)
      if (tbl_id[i] != FREE_ID) live.push_back(i);
    if (live.size() == 0) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return tbl_id[live[$urandom_range(0, live.size() - 1)]][ID_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] pick_id(bit for_create);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return ID_W'($urandom);
    if (r < 15) return $urandom_range(0, 1) ? ID_MAX : '0;
    if (for_create) return (r < 25) ? pick_live_id() : id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return (r < 60) ? pick_live_id() : id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  task automatic send_file_op(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id);
    int gap;
    req_t r;
    r.mode    = mode;
    r.file_id = id;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) begin
        req = req_t'({MODE_W'($urandom), ID_W'($urandom)});
        @(negedge clk);
      end
    end
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (req_stall);
    expected_rsps.push_back(apply_file_op(r));
    @(negedge clk);
  endtask

  task automatic test_directed();
    send_file_op(MODE_LOOKUP, '0);
    send_file_op(MODE_DELETE, ID_MAX);
    send_file_op(MODE_CREATE, '0);
    send_file_op(MODE_CREATE, ID_MAX);
    send_file_op(MODE_CREATE, '0);
    send_file_op(MODE_LOOKUP, ID_MAX);
    send_file_op(MODE_SPARE, '0);
    send_file_op(MODE_SPARE, 31'h1234_5678);
    send_file_op(MODE_DELETE, '0);
    send_file_op(MODE_DELETE, '0);
    send_file_op(MODE_LOOKUP, '0);
    send_file_op(MODE_CREATE, 31'h2AAA_AAAA);
    send_file_op(MODE_CREATE, 31'h5555_5555);
    send_file_op(MODE_LOOKUP, 31'h5555_5555);
    send_file_op(MODE_DELETE, ID_MAX);
    send_file_op(MODE_CREATE, ID_MAX);
    send_file_op(MODE_LOOKUP, ID_MAX);
    send_file_op(MODE_DELETE, 31'h2AAA_AAAA);
    send_file_op(MODE_LOOKUP, 31'h2AAA_AAAA);
  endtask

  task automatic test_inode_exhaustion();
    logic [ID_W-1:0] victim;
    for (int k = 0; k < NUM_INODES + 2; k++) send_file_op(MODE_CREATE, ID_W'($urandom));
    repeat (3) send_file_op(MODE_LOOKUP, pick_live_id());
    // free a slot in the middle and refill it
    victim = tbl_id[NUM_INODES / 2][ID_W-1:0];
    send_file_op(MODE_DELETE, victim);
    send_file_op(MODE_CREATE, ID_W'($urandom));
    send_file_op(MODE_CREATE, victim);
    for (int i = NUM_INODES - 1; i >= 0; i--)
      if (tbl_id[i] != FREE_ID) send_file_op(MODE_DELETE, tbl_id[i][ID_W-1:0]);
  endtask

  task automatic test_backpressure();
    gap_pct  = 0;
    hold_off = 1'b1;
    for (int k = 0; k < 16; k++) send_file_op(MODE_CREATE, id_pool[k]);
    repeat (4) send_file_op(MODE_LOOKUP, pick_live_id());
  endtask

  task automatic test_random_ops();
    int create_pct;
    int delete_pct;
    int r;
    logic [MODE_W-1:0] mode;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase % 3)
        0: begin
          create_pct = 60;
          delete_pct = 15;
        end
        1: begin
          create_pct = 20;
          delete_pct = 55;
        end
        default: begin
          create_pct = 35;
          delete_pct = 35;
        end
      endcase
      gap_pct   = (phase == 3) ? 0 : $urandom_range(10, 60);
      stall_pct = (phase == 3) ? 0 : $urandom_range(10, 60);
      repeat (250) begin
        r = $urandom_range(0, 99);
        if (r < 5) mode = MODE_SPARE;
        else if (r < 5 + create_pct) mode = MODE_CREATE;
        else if (r < 5 + create_pct + delete_pct) mode = MODE_DELETE;
        else mode = MODE_LOOKUP;
        send_file_op(mode, pick_id(mode == MODE_CREATE));
      end
    end
  endtask

  // receiver: random stalls, occasional long ones, and a long hold-off on request
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        hold_off = 1'b0;
        rsp_stall = 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < 2) begin
        rsp_stall = 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
        rsp_stall = 1'b0;
      end else begin
        rsp_stall = int'($urandom_range(0, 99)) < stall_pct;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result beat: %p", rsp);
        err_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          err_count++;
        end
        if (rsp.inode_slot !== want.inode_slot) begin
          $error("inode_slot: expected %0d, got %0d", want.inode_slot, rsp.inode_slot);
          err_count++;
        end
        if (rsp.block_number !== want.block_number) begin
          $error("block_number: expected %0d, got %0d", want.block_number, rsp.block_number);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("file_table_block_allocator verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    err_count   = 0;
    idle_cycles = 0;
    gap_pct     = 30;
    stall_pct   = 30;
    hold_off    = 1'b0;
    clear_file_table();
    id_pool[0] = '0;
    id_pool[1] = ID_MAX;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_inode_exhaustion();
    test_backpressure();
    test_random_ops();

    req_valid = 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (TAIL_LEN) @(posedge clk);
    if (err_count == 0) begin
      $display("file_table_block_allocator verification clean");
    end else begin
      $display("file_table_block_allocator verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ftba_pkg.sv
src/ftba_ram.sv
src/file_table_block_allocator.sv
verif/file_table_block_allocator_tb.sv
